@@ rtl/core/s2lab_pkg.sv @@
`default_nettype none

package s2lab_pkg;

   localparam int unsigned Q_BITS = 30;
   localparam int unsigned FW     = 31;
   localparam longint unsigned Q30 = 64'd1 << Q_BITS;

   localparam int unsigned CDIV_LAT = 4;
   // cube root chain (two stages per bit), linear branch input, divider, select
   localparam int unsigned LABF_LAT = 2 * FW + 1 + CDIV_LAT + 1;

   // linear branch of f(v): v <= 0.008856, then (9033 v + 160) / 1160
   localparam longint unsigned LIN_MAX = (64'd8856 * Q30) / 64'd1000000;
   localparam longint unsigned LIN_MUL = 64'd9033;
   localparam longint unsigned LIN_OFS = 64'd160 * Q30 + 64'd580;
   localparam longint unsigned LIN_DIV = 64'd1160;
   localparam int unsigned     LIN_NW  = 38;
   localparam longint unsigned F_MIN   = (64'd160 * Q30) / LIN_DIV;

   // RGB to XYZ matrix, units of 1e-4
   localparam logic [13:0] COEF [3][3] = '{
      '{14'd4124, 14'd3576, 14'd1805},
      '{14'd2126, 14'd7152, 14'd722},
      '{14'd193,  14'd1192, 14'd9505}
   };

   typedef logic [FW-1:0] lin_table_type [256];

   function automatic logic [FW-1:0] lin_entry(input longint unsigned c);
      longint unsigned t;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned m2;
      longint unsigned m5;
      longint unsigned tt;
      longint unsigned rr;
      if (c * 64'd100000 < 64'd1031475) begin
         return FW'((c * 64'd10 * Q30 + 64'd16473) / 64'd32946);
      end
      t  = (((64'd1000 * c + 64'd14025) << Q_BITS) + 64'd134512) / 64'd269025;
      lo = 64'd0;
      hi = Q30 + 64'd1;
      while (hi - lo > 64'd1) begin
         mid = lo + (hi - lo) / 64'd2;
         m2  = (mid * mid) >> Q_BITS;
         m5  = (((m2 * m2) >> Q_BITS) * mid) >> Q_BITS;
         if (m5 <= t) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      tt = (t * t) >> Q_BITS;
      rr = (lo * lo) >> Q_BITS;
      return FW'((tt * rr) >> Q_BITS);
   endfunction

   function automatic lin_table_type build_lin_table();
      lin_table_type tab;
      for (int i = 0; i < 256; i++) begin
         tab[i] = lin_entry(longint'(i));
      end
      return tab;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();

endpackage

`default_nettype wire

@@ rtl/core/s2lab_cdiv.sv @@
`default_nettype none

// floor(num / DIV): reciprocal multiply in two partial products, then one correction
module s2lab_cdiv #(
   parameter int unsigned     NW  = 47,
   parameter longint unsigned DIV = 95047,
   parameter int unsigned     QW  = 31
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   output logic [QW-1:0] quo
);

   localparam longint unsigned MUL_VAL = (64'd1 << NW) / DIV;
   localparam int unsigned     MW      = $clog2(MUL_VAL + 64'd1);
   localparam int unsigned     LO      = NW / 2;
   localparam int unsigned     HI      = NW - LO;
   localparam logic [MW-1:0]   MUL     = MW'(MUL_VAL);
   localparam logic [NW-1:0]   DIVN    = NW'(DIV);

   logic [LO+MW-1:0] plo_ff, plo_in;
   logic [HI+MW-1:0] phi_ff, phi_in;
   logic [NW-1:0]    n1_ff, n2_ff, n3_ff;
   logic [NW+MW-1:0] sum;
   logic [MW-1:0]    q0_ff, q0_in, q0b_ff, quo_ff, quo_in;
   logic [NW-1:0]    qd_ff, qd_in, rem;

   always_comb begin
      plo_in = (LO+MW)'(num[LO-1:0]) * (LO+MW)'(MUL);
      phi_in = (HI+MW)'(num[NW-1:LO]) * (HI+MW)'(MUL);
      sum    = ((NW+MW)'(phi_ff) << LO) + (NW+MW)'(plo_ff);
      q0_in  = sum[NW+MW-1:NW];
      qd_in  = NW'((NW+MW)'(q0_ff) * (NW+MW)'(DIV));
      rem    = n3_ff - qd_ff;
      // estimate is low by at most one
      quo_in = (rem >= DIVN) ? q0b_ff + 1'b1 : q0b_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         n1_ff  <= num;
         q0_ff  <= q0_in;
         n2_ff  <= n1_ff;
         qd_ff  <= qd_in;
         q0b_ff <= q0_ff;
         n3_ff  <= n2_ff;
         quo_ff <= quo_in;
      end
   end

   assign quo = QW'(quo_ff);

endmodule

`default_nettype wire

@@ rtl/core/s2lab_labf.sv @@
`default_nettype none

// CIELAB f(v): bitwise cube root chain, linear branch near black
module s2lab_labf import s2lab_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  logic [FW-1:0] v_in,
   output logic [FW-1:0] f_out
);

   localparam int unsigned STEPS = FW;

   logic [FW-1:0]   ta_ff [STEPS];
   logic [FW-1:0]   pa_ff [STEPS];
   logic [FW-1:0]   va_ff [STEPS];
   logic [FW:0]     sa_ff [STEPS];
   logic [FW-1:0]   fb_ff [STEPS];
   logic [FW-1:0]   vb_ff [STEPS];

   logic [FW-1:0]   fin   [STEPS];
   logic [FW-1:0]   vin   [STEPS];
   logic [FW-1:0]   trial [STEPS];
   logic [2*FW-1:0] sqf   [STEPS];
   logic [2*FW:0]   cubef [STEPS];
   logic            keep  [STEPS];

   logic [LIN_NW-1:0] n_ff, n_in;
   logic              sel1_ff;
   logic [FW-1:0]     fc1_ff;
   logic              seld_ff [CDIV_LAT];
   logic [FW-1:0]     fcd_ff  [CDIV_LAT];
   logic [FW-1:0]     lin_q;
   logic [FW-1:0]     f_ff;

   always_comb begin
      fin[0] = '0;
      vin[0] = v_in;
      for (int k = 1; k < STEPS; k++) begin
         fin[k] = fb_ff[k-1];
         vin[k] = vb_ff[k-1];
      end
      for (int k = 0; k < STEPS; k++) begin
         trial[k] = fin[k] | (FW'(1) << (FW - 1 - k));
         sqf[k]   = (2*FW)'(trial[k]) * (2*FW)'(trial[k]);
         cubef[k] = (2*FW+1)'(sa_ff[k]) * (2*FW+1)'(ta_ff[k]);
         keep[k]  = cubef[k][2*FW:Q_BITS] <= (2*FW+1-Q_BITS)'(va_ff[k]);
      end
      n_in = LIN_NW'(vb_ff[STEPS-1]) * LIN_NW'(LIN_MUL) + LIN_NW'(LIN_OFS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STEPS; k++) begin
            ta_ff[k] <= trial[k];
            pa_ff[k] <= fin[k];
            va_ff[k] <= vin[k];
            sa_ff[k] <= sqf[k][2*FW-1:Q_BITS];
            fb_ff[k] <= keep[k] ? ta_ff[k] : pa_ff[k];
            vb_ff[k] <= va_ff[k];
         end
         n_ff       <= n_in;
         sel1_ff    <= 64'(vb_ff[STEPS-1]) <= LIN_MAX;
         fc1_ff     <= fb_ff[STEPS-1];
         seld_ff[0] <= sel1_ff;
         fcd_ff[0]  <= fc1_ff;
         for (int k = 1; k < CDIV_LAT; k++) begin
            seld_ff[k] <= seld_ff[k-1];
            fcd_ff[k]  <= fcd_ff[k-1];
         end
         f_ff <= seld_ff[CDIV_LAT-1] ? lin_q : fcd_ff[CDIV_LAT-1];
      end
   end

   s2lab_cdiv #(
      .NW  (LIN_NW),
      .DIV (LIN_DIV),
      .QW  (FW)
   ) u_lin_div (
      .clock (clock),
      .en    (en),
      .num   (n_ff),
      .quo   (lin_q)
   );

   assign f_out = f_ff;

endmodule

`default_nettype wire

@@ rtl/core/srgb_to_cielab_unit.sv @@
`default_nettype none

// sRGB (8 bits a channel) to CIELAB under D65, one pixel per clock while no result waits
// on rsp_ready. An accepted request passes the table, matrix, divider, f(v) and output
// stages before its result shows on rsp_valid. The length is set by the cube root, which
// resolves one bit of f(v) every two stages with a multiplier in each. The whole pipeline
// advances together: when a result waits on rsp_ready, everything holds, and req_ready
// stays high while the output stage is empty or being taken. Results have 8 fraction bits.
module srgb_to_cielab_unit import s2lab_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [14:0] rsp_lightness,
   output logic signed [15:0] rsp_a_star,
   output logic signed [15:0] rsp_b_star
);

   localparam int unsigned F_IDX    = 3 + CDIV_LAT + LABF_LAT;
   localparam int unsigned PIPE_LAT = F_IDX + 3;

   function automatic logic [15:0] round_q22(input logic signed [41:0] num);
      logic [41:0] mag;
      logic [19:0] q;
      mag = num[41] ? 42'(-num) : 42'(num);
      q   = 20'((mag + (42'd1 << 21)) >> 22);
      if (num[41]) begin
         return (q >= 20'd32768) ? 16'h8000 : 16'(20'd0 - q);
      end
      return (q >= 20'd32767) ? 16'h7fff : q[15:0];
   endfunction

   logic en;
   logic vld_ff [PIPE_LAT];

   logic [FW-1:0] lin_ff  [3];
   logic [44:0]   prod_ff [3][3];
   logic [44:0]   prod_in [3][3];
   logic [43:0]   sum_ff  [3];
   logic [46:0]   nx_ff, nz_ff;
   logic [43:0]   ny_ff;
   logic [FW-1:0] xn, yn, zn;
   logic [FW-1:0] fx, fy, fz;

   logic signed [41:0] fxs, fys, fzs;
   logic signed [41:0] ln_ff, an_ff, bn_ff, ln_in;
   logic               lpos_ff;
   logic [15:0]        l_rnd;
   logic [14:0]        l_ff;
   logic [15:0]        a_ff, b_ff;

   assign en        = rsp_ready | ~vld_ff[PIPE_LAT-1];
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = 45'(lin_ff[j]) * 45'(COEF[i][j]);
         end
      end
   end

   // table lookup, matrix products, sums, rounding offsets
   always_ff @(posedge clock) begin
      if (en) begin
         lin_ff[0] <= LIN_TABLE[req_red];
         lin_ff[1] <= LIN_TABLE[req_green];
         lin_ff[2] <= LIN_TABLE[req_blue];
         prod_ff   <= prod_in;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= 44'(prod_ff[i][0] + prod_ff[i][1] + prod_ff[i][2]);
         end
         nx_ff <= 47'(sum_ff[0]) * 47'd10 + 47'd47523;
         ny_ff <= sum_ff[1] + 44'd5000;
         nz_ff <= 47'(sum_ff[2]) * 47'd10 + 47'd54441;
      end
   end

   s2lab_cdiv #(.NW(47), .DIV(95047),  .QW(FW)) u_div_x (
      .clock (clock), .en (en), .num (nx_ff), .quo (xn));
   s2lab_cdiv #(.NW(44), .DIV(10000),  .QW(FW)) u_div_y (
      .clock (clock), .en (en), .num (ny_ff), .quo (yn));
   s2lab_cdiv #(.NW(47), .DIV(108883), .QW(FW)) u_div_z (
      .clock (clock), .en (en), .num (nz_ff), .quo (zn));

   s2lab_labf u_f_x (.clock (clock), .en (en), .v_in (xn), .f_out (fx));
   s2lab_labf u_f_y (.clock (clock), .en (en), .v_in (yn), .f_out (fy));
   s2lab_labf u_f_z (.clock (clock), .en (en), .v_in (zn), .f_out (fz));

   assign fxs   = signed'(42'(fx));
   assign fys   = signed'(42'(fy));
   assign fzs   = signed'(42'(fz));
   assign ln_in = fys * 42'sd116 - signed'(42'(64'd16 * Q30));
   assign l_rnd = round_q22(ln_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         ln_ff   <= ln_in;
         lpos_ff <= ln_in > 42'sd0;
         an_ff   <= (fxs - fys) * 42'sd500;
         bn_ff   <= (fys - fzs) * 42'sd200;
         l_ff    <= lpos_ff ? l_rnd[14:0] : 15'd0;
         a_ff    <= round_q22(an_ff);
         b_ff    <= round_q22(bn_ff);
      end
   end

   assign rsp_valid     = vld_ff[PIPE_LAT-1];
   assign rsp_lightness = l_ff;
   assign rsp_a_star    = signed'(a_ff);
   assign rsp_b_star    = signed'(b_ff);

   a_l_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lightness <= 15'd25600)
      else $error("lightness beyond 100");

   a_f_floor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[F_IDX] |-> 64'(fy) >= F_MIN && 64'(fx) >= F_MIN && 64'(fz) >= F_MIN)
      else $error("f(v) below its lower bound");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline held");

endmodule

`default_nettype wire
